// File: hw/rtl/erm_pkg.sv
// ----------------------------------------------------------------------------
// Event rate meter package
// Widths, register indexes and constants shared by the rate meter modules.
// ----------------------------------------------------------------------------
package erm_pkg;

	// field widths
	localparam int TS_W     = 64;
	localparam int CFG_W    = 40;
	localparam int RATE_W   = 32;
	localparam int CNT_W    = 32;
	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 40;

	// configuration register indexes
	localparam logic REG_STALE_LIMIT   = 1'b0;
	localparam logic REG_SAMPLE_PERIOD = 1'b1;

	// configuration reset values
	localparam logic [CFG_W-1:0] STALE_LIMIT_RST   = 40'd1000000000;
	localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 40'd500000000;

	// nanoseconds per second, taken four bits per cycle by the multiplier
	localparam logic [CNT_W-1:0] NS_PER_SEC = 32'd1000000000;
	localparam int               MUL_DIG_W  = 4;
	localparam int               MUL_DIGITS = 8;
	localparam int               MUL_IDX_W  = $clog2(MUL_DIGITS);

	// counter width for the iterations of the bit-serial divider
	localparam int DIV_CNT_W = $clog2(TS_W);

endpackage

// File: hw/rtl/erm_div.sv
// ----------------------------------------------------------------------------
// Rate meter divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module erm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [erm_pkg::TS_W-1:0]  num,
	input  logic [erm_pkg::TS_W-1:0]  den,
	output logic                      done,
	output logic [erm_pkg::TS_W-1:0]  quo
);
	import erm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]      rem_q;
	logic [TS_W-1:0]      quo_q;
	logic [TS_W-1:0]      den_q;
	logic [TS_W:0]        trial;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[TS_W-1]} - {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(TS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[TS_W]) begin
				rem_q <= trial[TS_W-1:0];
			end else begin
				rem_q <= {rem_q[TS_W-2:0], quo_q[TS_W-1]};
			end
			quo_q <= {quo_q[TS_W-2:0], ~trial[TS_W]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: hw/rtl/event_rate_meter_top.sv
// ----------------------------------------------------------------------------
// Event rate meter
// Windowed rate of timestamped events, rounded and saturated to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one beat per event, tdata = timestamp in ns (zero means
//   no event). Master stream m_*: one beat per input beat carrying the sample
//   strobe, the latest rate in events per second and its valid flag.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index
//   (0 = stale limit, 1 = sample period) at the clock edge; write only while
//   the block is idle.
// Data path:
//   A beat that does not close a window passes from the evaluate state to the
//   done state and on to m_*. A beat that closes a window goes through the
//   4-bit serial multiplier and the bit-serial 64-bit divider before it
//   appears on m_*. One event is in work at a time; s_tready rises again
//   once the result has moved into the output register.
// Reset and stall:
//   Reset clears the measurement state, loads the register defaults and
//   empties the output register. While m_tready is low a finished result
//   waits in the output register; the next event is still accepted and
//   waits for that register before it is delivered.
// ----------------------------------------------------------------------------
module event_rate_meter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// timestamp_ns [63:0]
	input  logic [erm_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sampled [0], rate_fps [32:1], rate_valid [33], zero pad [39:34]
	output logic [erm_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [erm_pkg::CFG_W-1:0]     cfg_wdata
);
	import erm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]           state_q;
	logic [CFG_W-1:0]     stale_q;
	logic [CFG_W-1:0]     period_q;
	logic                 running_q;
	logic                 have_rate_q;
	logic [TS_W-1:0]      window_start_q;
	logic [TS_W-1:0]      last_event_q;
	logic [CNT_W-1:0]     count_q;
	logic [RATE_W-1:0]    rate_q;
	logic                 sampled_q;
	logic [TS_W-1:0]      t_q;
	logic [TS_W-1:0]      elapsed_q;
	logic [TS_W-1:0]      acc_q;
	logic [MUL_IDX_W-1:0] mul_idx_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic                 m_tvalid_q;

	logic                 s_accept;
	logic                 out_free;
	logic [TS_W-1:0]      gap;
	logic [TS_W-1:0]      elapsed;
	logic [TS_W-1:0]      period;
	logic                 restart;
	logic                 close_win;
	logic [CNT_W-1:0]     count_inc;
	logic [MUL_DIG_W-1:0] digit;
	logic [CNT_W+MUL_DIG_W-1:0] prod;
	logic                 div_start;
	logic                 div_done;
	logic [TS_W-1:0]      div_num;
	logic [TS_W-1:0]      quo;
	logic [RATE_W-1:0]    rate_sat;

	assign s_accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// event classification
	assign gap       = t_q - last_event_q;
	assign elapsed   = t_q - window_start_q;
	assign period    = (period_q == '0) ? TS_W'(1) : TS_W'(period_q);
	assign restart   = !running_q || (t_q < last_event_q) || (gap > TS_W'(stale_q));
	assign close_win = (elapsed >= period);
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

	// serial multiply: count times one 4-bit digit of 1e9, high digit first
	assign digit = MUL_DIG_W'(NS_PER_SEC >> {mul_idx_q, 2'b00});
	assign prod  = (CNT_W+MUL_DIG_W)'(count_q) * (CNT_W+MUL_DIG_W)'(digit);

	// numerator with half the divisor added for round to nearest
	assign div_start = (state_q == ST_LOAD);
	assign div_num   = acc_q + {1'b0, elapsed_q[TS_W-1:1]};

	erm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (elapsed_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign rate_sat = (quo[TS_W-1:RATE_W] != '0) ? '1 : quo[RATE_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q  <= STALE_LIMIT_RST;
			period_q <= SAMPLE_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STALE_LIMIT:   stale_q  <= cfg_wdata;
				REG_SAMPLE_PERIOD: period_q <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	// sequencer and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			running_q      <= 1'b0;
			have_rate_q    <= 1'b0;
			window_start_q <= '0;
			last_event_q   <= '0;
			count_q        <= '0;
			rate_q         <= '0;
			sampled_q      <= 1'b0;
			mul_idx_q      <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			// output valid: set when a result loads, cleared once taken
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (t_q == '0) begin
						// no event: report the current rate only
						sampled_q <= 1'b0;
						state_q   <= ST_DONE;
					end else if (restart) begin
						running_q      <= 1'b1;
						have_rate_q    <= 1'b0;
						window_start_q <= t_q;
						last_event_q   <= t_q;
						count_q        <= '0;
						sampled_q      <= 1'b0;
						state_q        <= ST_DONE;
					end else begin
						last_event_q <= t_q;
						count_q      <= count_inc;
						if (close_win) begin
							sampled_q <= 1'b1;
							mul_idx_q <= MUL_IDX_W'(MUL_DIGITS - 1);
							state_q   <= ST_MUL;
						end else begin
							sampled_q <= 1'b0;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					mul_idx_q <= mul_idx_q - 1'b1;
					if (mul_idx_q == '0) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						rate_q         <= rate_sat;
						have_rate_q    <= 1'b1;
						window_start_q <= t_q;
						count_q        <= '0;
						state_q        <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			t_q <= s_tdata[TS_W-1:0];
		end
		if (state_q == ST_EVAL) begin
			elapsed_q <= elapsed;
			acc_q     <= '0;
		end else if (state_q == ST_MUL) begin
			acc_q <= {acc_q[TS_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}} + TS_W'(prod);
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {{(M_DATA_W-RATE_W-2){1'b0}}, have_rate_q,
				(have_rate_q ? rate_q : {RATE_W{1'b0}}), sampled_q};
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tvalid = m_tvalid_q;

	// checks
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide step");

	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == ST_EVAL))
		else $error("accepted beat not evaluated next cycle");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (running_q && elapsed_q != '0))
		else $error("divide started with zero elapsed time");

	a_sampled_has_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && sampled_q) |-> have_rate_q)
		else $error("window closed without a valid rate");

endmodule
